// File: rtl/core/vlcw_pkg.sv
// shared constants, job record and helpers for the voxel line cell walker
// no dependencies; imported by every module of the block
package vlcw_pkg;

  localparam int GRID_XY   = 512;
  localparam int GRID_Z    = 64;
  localparam int MAX_CELLS = 64;

  localparam int XY_W    = 9;
  localparam int Z_W     = 6;
  localparam int END_W   = 12;
  localparam int DELTA_W = END_W + 1;
  localparam int ABS_W   = 12;
  localparam int FRAC_W  = 10;
  localparam int INC_W   = ABS_W + FRAC_W;
  // accumulators never exceed 65 times the largest increment
  localparam int ACC_W   = 28;
  localparam int IDX_W   = 6;

  // divider retires two quotient bits per cycle
  localparam int DIV_CYCLES = INC_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [INC_W-1:0] DOM_INC        = INC_W'(1024);
  localparam logic [INC_W-1:0] ZERO_DELTA_INC = INC_W'(2097151);

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // one prepared line, handed from setup to the walker
  typedef struct packed {
    logic [XY_W-1:0]  sx;
    logic [XY_W-1:0]  sy;
    logic [Z_W-1:0]   sz;
    logic [END_W-1:0] ex;
    logic [END_W-1:0] ey;
    logic [END_W-1:0] ez;
    logic [INC_W-1:0] inc_x;
    logic [INC_W-1:0] inc_y;
    logic [INC_W-1:0] inc_z;
    logic [INC_W-1:0] acc_x;
    logic [INC_W-1:0] acc_y;
    logic [INC_W-1:0] acc_z;
    logic [2:0]       neg;
  } job_t;

  // half-step start offset, flipped for a non-negative direction
  function automatic logic [INC_W-1:0] start_acc(input logic [INC_W-1:0] inc,
                                                 input logic neg);
    logic [INC_W-1:0] half;
    half = inc >> 1;
    return neg ? half : (inc - half);
  endfunction

endpackage

// File: rtl/core/vlcw_div.sv
// radix-4 restoring divider for the minor-axis increments
// depends on vlcw_pkg
module vlcw_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [vlcw_pkg::INC_W-1:0] dividend,
  input  logic [vlcw_pkg::ABS_W-1:0] divisor,
  output logic                      done,
  output logic [vlcw_pkg::INC_W-1:0] quotient
);
  import vlcw_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [ABS_W:0]       rem;
  logic [ABS_W-1:0]     div_r;
  logic [ABS_W:0]       rem_next;
  logic [INC_W-1:0]     quo_next;

  // two dependent shift-subtract steps per cycle
  always_comb begin
    logic [ABS_W:0] shifted;
    rem_next = rem;
    quo_next = quotient;
    for (int i = 0; i < 2; i++) begin
      shifted  = {rem_next[ABS_W-1:0], quo_next[INC_W-1]};
      quo_next = {quo_next[INC_W-2:0], 1'b0};
      if (shifted >= {1'b0, div_r}) begin
        rem_next    = shifted - {1'b0, div_r};
        quo_next[0] = 1'b1;
      end else begin
        rem_next = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= '0;
        rem      <= '0;
        quotient <= dividend;
        div_r    <= divisor;
      end else if (busy) begin
        rem      <= rem_next;
        quotient <= quo_next;
        count    <= count + 1'b1;
        if (count == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/vlcw_front.sv
// setup stage: accepts a line, finds the dominant axis, runs the increment divisions
// depends on vlcw_pkg and vlcw_div
module vlcw_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       line_valid,
  output logic                       line_stall,
  input  logic [vlcw_pkg::XY_W-1:0]  start_x,
  input  logic [vlcw_pkg::XY_W-1:0]  start_y,
  input  logic [vlcw_pkg::Z_W-1:0]   start_z,
  input  logic signed [vlcw_pkg::END_W-1:0] end_x,
  input  logic signed [vlcw_pkg::END_W-1:0] end_y,
  input  logic signed [vlcw_pkg::END_W-1:0] end_z,
  output logic                       push_valid,
  output vlcw_pkg::job_t             push_job,
  input  logic                       push_full
);
  import vlcw_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV_A_GO,
    F_DIV_A,
    F_DIV_B_GO,
    F_DIV_B,
    F_PUSH
  } fstate_t;

  fstate_t          state;
  logic [XY_W-1:0]  sx, sy;
  logic [Z_W-1:0]   sz;
  logic [END_W-1:0] ex, ey, ez;
  logic [ABS_W-1:0] abs_x, abs_y, abs_z;
  logic [2:0]       neg;
  axis_t            dom;
  logic [INC_W-1:0] quo_a, quo_b;

  logic [DELTA_W-1:0] dx_in, dy_in, dz_in;
  logic [ABS_W-1:0]   ax_in, ay_in, az_in;
  axis_t              dom_in;
  logic [ABS_W-1:0]   dom_abs, minor_a_abs, minor_b_abs;
  logic [INC_W-1:0]   inc_a, inc_b, inc_x, inc_y, inc_z;
  logic               div_start, div_done;
  logic [INC_W-1:0]   div_quo;

  function automatic logic [ABS_W-1:0] mag(input logic [DELTA_W-1:0] d);
    logic [DELTA_W-1:0] m;
    m = d[DELTA_W-1] ? (~d + 1'b1) : d;
    return m[ABS_W-1:0];
  endfunction

  assign dx_in = {end_x[END_W-1], end_x} - {{(DELTA_W-XY_W){1'b0}}, start_x};
  assign dy_in = {end_y[END_W-1], end_y} - {{(DELTA_W-XY_W){1'b0}}, start_y};
  assign dz_in = {end_z[END_W-1], end_z} - {{(DELTA_W-Z_W){1'b0}}, start_z};
  assign ax_in = mag(dx_in);
  assign ay_in = mag(dy_in);
  assign az_in = mag(dz_in);

  // ties go to x, then y
  always_comb begin
    if (ax_in >= ay_in && ax_in >= az_in) begin
      dom_in = AXIS_X;
    end else if (ay_in >= az_in) begin
      dom_in = AXIS_Y;
    end else begin
      dom_in = AXIS_Z;
    end
  end

  always_comb begin
    unique case (dom)
      AXIS_X: begin
        dom_abs = abs_x; minor_a_abs = abs_y; minor_b_abs = abs_z;
      end
      AXIS_Y: begin
        dom_abs = abs_y; minor_a_abs = abs_x; minor_b_abs = abs_z;
      end
      AXIS_Z: begin
        dom_abs = abs_z; minor_a_abs = abs_x; minor_b_abs = abs_y;
      end
      default: begin
        dom_abs = abs_x; minor_a_abs = abs_y; minor_b_abs = abs_z;
      end
    endcase
  end

  assign inc_a = (minor_a_abs == '0) ? ZERO_DELTA_INC : quo_a;
  assign inc_b = (minor_b_abs == '0) ? ZERO_DELTA_INC : quo_b;

  always_comb begin
    unique case (dom)
      AXIS_X: begin
        inc_x = DOM_INC; inc_y = inc_a; inc_z = inc_b;
      end
      AXIS_Y: begin
        inc_x = inc_a; inc_y = DOM_INC; inc_z = inc_b;
      end
      AXIS_Z: begin
        inc_x = inc_a; inc_y = inc_b; inc_z = DOM_INC;
      end
      default: begin
        inc_x = DOM_INC; inc_y = inc_a; inc_z = inc_b;
      end
    endcase
  end

  assign div_start = (state == F_DIV_A_GO) || (state == F_DIV_B_GO);

  vlcw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({dom_abs, {FRAC_W{1'b0}}}),
    .divisor  ((state == F_DIV_A_GO) ? minor_a_abs : minor_b_abs),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign line_stall = (state != F_IDLE);
  assign push_valid = (state == F_PUSH);

  assign push_job.sx    = sx;
  assign push_job.sy    = sy;
  assign push_job.sz    = sz;
  assign push_job.ex    = ex;
  assign push_job.ey    = ey;
  assign push_job.ez    = ez;
  assign push_job.inc_x = inc_x;
  assign push_job.inc_y = inc_y;
  assign push_job.inc_z = inc_z;
  assign push_job.acc_x = start_acc(inc_x, neg[0]);
  assign push_job.acc_y = start_acc(inc_y, neg[1]);
  assign push_job.acc_z = start_acc(inc_z, neg[2]);
  assign push_job.neg   = neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (line_valid) begin
            sx    <= start_x;
            sy    <= start_y;
            sz    <= start_z;
            ex    <= end_x;
            ey    <= end_y;
            ez    <= end_z;
            abs_x <= ax_in;
            abs_y <= ay_in;
            abs_z <= az_in;
            neg   <= {dz_in[DELTA_W-1], dy_in[DELTA_W-1], dx_in[DELTA_W-1]};
            dom   <= dom_in;
            state <= F_DIV_A_GO;
          end
        end
        F_DIV_A_GO: state <= F_DIV_A;
        F_DIV_A: begin
          if (div_done) begin
            quo_a <= div_quo;
            state <= F_DIV_B_GO;
          end
        end
        F_DIV_B_GO: state <= F_DIV_B;
        F_DIV_B: begin
          if (div_done) begin
            quo_b <= div_quo;
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!push_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/vlcw_queue.sv
// short job queue between setup and the walker
// depends on vlcw_pkg
module vlcw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  vlcw_pkg::job_t push_job,
  output logic           push_full,
  input  logic           pop,
  output logic           pop_valid,
  output vlcw_pkg::job_t pop_job
);
  import vlcw_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_full = (fill == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_job   = entries[rd_ptr];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_job;
        wr_ptr          <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/vlcw_back.sv
// walker: steps a prepared line one cell per cycle into the output register while cell_stall is low
// depends on vlcw_pkg
module vlcw_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pop_valid,
  input  vlcw_pkg::job_t            pop_job,
  output logic                      pop,
  output logic                      cell_valid,
  input  logic                      cell_stall,
  output logic [vlcw_pkg::XY_W-1:0] cell_x,
  output logic [vlcw_pkg::XY_W-1:0] cell_y,
  output logic [vlcw_pkg::Z_W-1:0]  cell_z,
  output logic [vlcw_pkg::IDX_W-1:0] cell_index,
  output logic                      last
);
  import vlcw_pkg::*;

  logic             active;
  logic [XY_W-1:0]  cur_x, cur_y;
  logic [Z_W-1:0]   cur_z;
  logic [ACC_W-1:0] acc_x, acc_y, acc_z;
  logic [INC_W-1:0] inc_x, inc_y, inc_z;
  logic [2:0]       neg;
  logic [END_W-1:0] ex, ey, ez;
  logic [IDX_W-1:0] count;

  axis_t pick;
  logic  out_free, at_end, at_max, edge_hit, done;

  assign pop      = !active && pop_valid;
  assign out_free = !cell_valid || !cell_stall;

  // smallest accumulator wins, ties to z then y
  always_comb begin
    if (acc_z <= acc_x && acc_z <= acc_y) begin
      pick = AXIS_Z;
    end else if (acc_x < acc_y) begin
      pick = AXIS_X;
    end else begin
      pick = AXIS_Y;
    end
  end

  assign at_end = (END_W'(cur_x) == ex) && (END_W'(cur_y) == ey) && (END_W'(cur_z) == ez);
  assign at_max = (count == IDX_W'(MAX_CELLS - 1));

  always_comb begin
    unique case (pick)
      AXIS_X:  edge_hit = neg[0] ? (cur_x == '0) : (cur_x == XY_W'(GRID_XY - 1));
      AXIS_Y:  edge_hit = neg[1] ? (cur_y == '0) : (cur_y == XY_W'(GRID_XY - 1));
      AXIS_Z:  edge_hit = neg[2] ? (cur_z == '0) : (cur_z == Z_W'(GRID_Z - 1));
      default: edge_hit = 1'b1;
    endcase
  end

  assign done = at_max || at_end || edge_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      cell_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
        cur_x  <= pop_job.sx;
        cur_y  <= pop_job.sy;
        cur_z  <= pop_job.sz;
        ex     <= pop_job.ex;
        ey     <= pop_job.ey;
        ez     <= pop_job.ez;
        inc_x  <= pop_job.inc_x;
        inc_y  <= pop_job.inc_y;
        inc_z  <= pop_job.inc_z;
        acc_x  <= ACC_W'(pop_job.acc_x);
        acc_y  <= ACC_W'(pop_job.acc_y);
        acc_z  <= ACC_W'(pop_job.acc_z);
        neg    <= pop_job.neg;
        count  <= '0;
        if (!cell_stall) begin
          cell_valid <= 1'b0;
        end
      end else if (active && out_free) begin
        cell_valid <= 1'b1;
        cell_x     <= cur_x;
        cell_y     <= cur_y;
        cell_z     <= cur_z;
        cell_index <= count;
        last       <= done;
        if (done) begin
          active <= 1'b0;
        end else begin
          count <= count + 1'b1;
          case (pick)
            AXIS_X: begin
              cur_x <= neg[0] ? cur_x - 1'b1 : cur_x + 1'b1;
              acc_x <= acc_x + ACC_W'(inc_x);
            end
            AXIS_Y: begin
              cur_y <= neg[1] ? cur_y - 1'b1 : cur_y + 1'b1;
              acc_y <= acc_y + ACC_W'(inc_y);
            end
            default: begin
              cur_z <= neg[2] ? cur_z - 1'b1 : cur_z + 1'b1;
              acc_z <= acc_z + ACC_W'(inc_z);
            end
          endcase
        end
      end else if (!cell_stall) begin
        // pending cell taken and nothing new to send
        cell_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/voxel_line_cell_walker.sv
// top level of the voxel line cell walker: setup, job queue and walker
// depends on vlcw_pkg, vlcw_front, vlcw_queue and vlcw_back
// usage
//   line channel (line_valid / line_stall): one item is a start cell inside the grid
//   and an end cell that may lie outside it, taken with line_valid high, line_stall low.
//   cell channel (cell_valid / cell_stall): the cells the line passes through, from
//   the start cell on, with their run index; last marks the final cell of a run.
//   a run ends on the end cell, after 64 cells, or before a step that would leave
//   the grid; such an out-of-grid cell is never sent.
// timing
//   setup turns an item into a job in the queue with two 22-bit divisions at two
//   quotient bits per cycle on one shared divider, each with a start state and a
//   capture state, then the push; line_stall stays high meanwhile, so the line
//   channel takes no new item until that job is pushed.
//   once the walker takes the job it sends one cell per cycle while cell_stall is low,
//   and the two-entry job queue lets setup of the next line overlap a walk.
// reset and stalls
//   rst is synchronous, active high; it empties the queue and drops any run and any
//   pending cell. while cell_stall is high the pending cell holds and the walker waits.
module voxel_line_cell_walker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        line_valid,
  output logic                        line_stall,
  input  logic [vlcw_pkg::XY_W-1:0]   start_x,
  input  logic [vlcw_pkg::XY_W-1:0]   start_y,
  input  logic [vlcw_pkg::Z_W-1:0]    start_z,
  input  logic signed [vlcw_pkg::END_W-1:0] end_x,
  input  logic signed [vlcw_pkg::END_W-1:0] end_y,
  input  logic signed [vlcw_pkg::END_W-1:0] end_z,
  output logic                        cell_valid,
  input  logic                        cell_stall,
  output logic [vlcw_pkg::XY_W-1:0]   cell_x,
  output logic [vlcw_pkg::XY_W-1:0]   cell_y,
  output logic [vlcw_pkg::Z_W-1:0]    cell_z,
  output logic [vlcw_pkg::IDX_W-1:0]  cell_index,
  output logic                        last
);
  import vlcw_pkg::*;

  // setup to queue
  logic push_valid, push_full;
  job_t push_job;
  // queue to walker
  logic pop, pop_valid;
  job_t pop_job;

  vlcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .line_valid (line_valid),
    .line_stall (line_stall),
    .start_x    (start_x),
    .start_y    (start_y),
    .start_z    (start_z),
    .end_x      (end_x),
    .end_y      (end_y),
    .end_z      (end_z),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_full  (push_full)
  );

  vlcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_full  (push_full),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job)
  );

  vlcw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop        (pop),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_z     (cell_z),
    .cell_index (cell_index),
    .last       (last)
  );

`ifndef SYNTH
  // within a run the walker refills the output register in the very next cycle
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !cell_stall && !last |=> cell_valid)
    else $error("run broke off before its last cell");

  // run index counts up by one from cell to cell
  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !cell_stall && !last |=>
      cell_index == IDX_W'($past(cell_index) + 1'b1))
    else $error("cell index did not advance by one");

  // a new run always starts at index zero
  a_index_restarts: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !cell_stall && last |=> !cell_valid || cell_index == '0)
    else $error("run did not start at index zero");

  // setup never pushes into a full queue without holding the job
  a_queue_hold: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_full |=> push_valid)
    else $error("setup dropped a job on a full queue");
`endif

endmodule
